// File: design/isa23_pkg.sv
`default_nettype none

package isa23_pkg;

  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 12;
  localparam int HS_W       = 10;
  localparam int V_W        = 12;
  localparam int PROD_W     = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int MAX_WIDTH_DEF = 1536;
  localparam int IMG_W_RST     = 1536;
  localparam int IMG_H_RST     = 1024;

  // x/3 by reciprocal, exact over the ranges used
  localparam int DIV3_W_MUL   = 171;
  localparam int DIV3_W_SHIFT = 9;
  localparam int DIV3_H_MUL   = 2731;
  localparam int DIV3_H_SHIFT = 13;
  localparam int GROUP_COLS   = 24;

  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    GPH_LEFT  = 2'd0,
    GPH_MID   = 2'd1,
    GPH_RIGHT = 2'd2
  } gph_t;

  typedef enum logic [1:0] {
    RPH_TOP = 2'd0,
    RPH_MID = 2'd1,
    RPH_BOT = 2'd2
  } rph_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [HS_W-1:0] hs;
    rph_t            rph;
    logic            row_end;
    logic            frame_end;
  } lane_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

`default_nettype wire

// File: design/isa23_store.sv
`default_nettype none

module isa23_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                     clk,
  input  isa23_pkg::store_ctl_t    ctl,
  input  logic [ADDR_W-1:0]        addr,
  input  logic [isa23_pkg::HS_W-1:0] wdata,
  output logic [isa23_pkg::HS_W-1:0] rd_data
);
  import isa23_pkg::*;

  logic [HS_W-1:0] mem [DEPTH];
  logic [HS_W-1:0] rd_data_r;

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/isa23_ctrl.sv
`default_nettype none

module isa23_ctrl #(
  parameter int MAX_WIDTH = 1536,
  parameter int ADDR_W    = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [isa23_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isa23_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  input  isa23_pkg::in_item_t               in_item,
  input  logic                              adv,
  output logic                              lane_valid,
  output isa23_pkg::lane_t                  lane,
  output isa23_pkg::store_ctl_t             st_ctl,
  output logic [ADDR_W-1:0]                 st_addr,
  output logic [isa23_pkg::HS_W-1:0]        st_wdata
);
  import isa23_pkg::*;

  localparam int W_MAX_CODE = (1 << IMG_W_W) - 1;
  localparam logic [IMG_W_W-1:0] W_CLAMP =
    IMG_W_W'((MAX_WIDTH > W_MAX_CODE) ? W_MAX_CODE : MAX_WIDTH);
  localparam int RST_EW = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;
  localparam logic [IMG_W_W-1:0] UW_RST =
    IMG_W_W'((RST_EW / GROUP_COLS) * GROUP_COLS);
  localparam logic [IMG_H_W-1:0] UH_RST = IMG_H_W'((IMG_H_RST / 3) * 3);

  logic [IMG_W_W-1:0] width_r, uw_r;
  logic [IMG_H_W-1:0] height_r, uh_r;
  logic [IMG_W_W-1:0] col_r, col_nxt, grp_r, grp_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;
  gph_t               cph_r, cph_nxt;
  rph_t               rph_r, rph_nxt;
  logic [PIX_W-1:0]   first_r, first_nxt, second_r, second_nxt;

  // config decode
  logic [IMG_W_W-1:0] cfg_w, cfg_ew, uw_nxt;
  logic [15:0]        w_q;
  logic [6:0]         w_grp;
  logic [IMG_H_W-1:0] cfg_h, uh_nxt;
  logic [23:0]        h_q;
  logic [10:0]        h_grp;

  always_comb begin
    cfg_w  = cfg_wdata[IMG_W_W-1:0];
    cfg_ew = (cfg_w > W_CLAMP) ? W_CLAMP : cfg_w;
    w_q    = 16'(cfg_ew[IMG_W_W-1:3]) * 16'(DIV3_W_MUL);
    w_grp  = 7'(w_q >> DIV3_W_SHIFT);
    uw_nxt = IMG_W_W'(11'(w_grp) * 11'(GROUP_COLS));
    cfg_h  = cfg_wdata[IMG_H_W-1:0];
    h_q    = 24'(cfg_h) * 24'(DIV3_H_MUL);
    h_grp  = 11'(h_q >> DIV3_H_SHIFT);
    uh_nxt = IMG_H_W'(12'(h_grp) * 12'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMG_W_W'(IMG_W_RST);
      height_r <= IMG_H_W'(IMG_H_RST);
      uw_r     <= UW_RST;
      uh_r     <= UH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= cfg_w;
          uw_r    <= uw_nxt;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= cfg_h;
          uh_r     <= uh_nxt;
        end
      endcase
    end
  end

  // per-pixel decode
  logic               acc, fs, active, pair, do_rd, do_wr;
  logic [PIX_W-1:0]   pix;
  logic [IMG_W_W-1:0] col_e, grp_e, idx;
  logic [IMG_H_W-1:0] row_e;
  gph_t               cph_e;
  rph_t               rph_e;
  logic [HS_W-1:0]    hs;
  logic               wrap_col, wrap_row;

  always_comb begin
    acc    = in_valid && adv;
    fs     = in_item.frame_start;
    pix    = in_item.pixel_in;
    col_e  = fs ? '0 : col_r;
    row_e  = fs ? '0 : row_r;
    grp_e  = fs ? '0 : grp_r;
    cph_e  = fs ? GPH_LEFT : cph_r;
    rph_e  = fs ? RPH_TOP : rph_r;
    active = (col_e < uw_r) && (row_e < uh_r);

    case (cph_e)
      GPH_MID:   hs = HS_W'({first_r, 1'b0}) + HS_W'(pix);
      GPH_RIGHT: hs = HS_W'(second_r) + HS_W'({pix, 1'b0});
      default:   hs = '0;
    endcase

    pair  = active && (cph_e != GPH_LEFT);
    do_wr = pair && ((rph_e == RPH_TOP) || (rph_e == RPH_MID));
    do_rd = pair && ((rph_e == RPH_MID) || (rph_e == RPH_BOT));
    idx   = grp_e + ((cph_e == GPH_RIGHT) ? 11'd1 : 11'd0);

    st_ctl.rd_en = acc && do_rd;
    st_ctl.wr_en = acc && do_wr;
    st_addr      = ADDR_W'(idx);
    st_wdata     = hs;

    lane.hs        = hs;
    lane.rph       = rph_e;
    lane.row_end   = (col_e == uw_r - 11'd1);
    lane.frame_end = lane.row_end && (row_e == uh_r - 12'd1);
    lane_valid     = acc && do_rd;

    first_nxt  = (active && cph_e == GPH_LEFT) ? pix : first_r;
    second_nxt = (active && cph_e == GPH_MID) ? pix : second_r;

    wrap_col = (12'(col_e) + 12'd1) >= 12'(width_r);
    wrap_row = (13'(row_e) + 13'd1) >= 13'(height_r);
    if (wrap_col) begin
      col_nxt = '0;
      grp_nxt = '0;
      cph_nxt = GPH_LEFT;
      if (wrap_row) begin
        row_nxt = '0;
        rph_nxt = RPH_TOP;
      end else begin
        row_nxt = row_e + 12'd1;
        case (rph_e)
          RPH_TOP: rph_nxt = RPH_MID;
          RPH_MID: rph_nxt = RPH_BOT;
          default: rph_nxt = RPH_TOP;
        endcase
      end
    end else begin
      col_nxt = col_e + 11'd1;
      row_nxt = row_e;
      rph_nxt = rph_e;
      case (cph_e)
        GPH_LEFT: begin
          cph_nxt = GPH_MID;
          grp_nxt = grp_e;
        end
        GPH_MID: begin
          cph_nxt = GPH_RIGHT;
          grp_nxt = grp_e;
        end
        default: begin
          cph_nxt = GPH_LEFT;
          grp_nxt = grp_e + 11'd2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      grp_r    <= '0;
      cph_r    <= GPH_LEFT;
      rph_r    <= RPH_TOP;
      first_r  <= '0;
      second_r <= '0;
    end else if (acc) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      grp_r    <= grp_nxt;
      cph_r    <= cph_nxt;
      rph_r    <= rph_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/isa23_filt.sv
`default_nettype none

module isa23_filt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        s0_valid,
  input  isa23_pkg::lane_t            s0,
  input  logic [isa23_pkg::HS_W-1:0]  rd_data,
  output logic                        out_valid,
  output isa23_pkg::out_item_t        out_item
);
  import isa23_pkg::*;

  logic        s1_valid_r, s2_valid_r, out_valid_r;
  lane_t       s1_r;
  logic [V_W-1:0] v_nxt, v_r;
  logic        s2_row_end_r, s2_frame_end_r;
  logic [PROD_W-1:0] prod;
  out_item_t   out_item_r;

  // nine times the output: vertical weighting of the two row sums
  always_comb begin
    case (s1_r.rph)
      RPH_MID: v_nxt = V_W'({rd_data, 1'b0}) + V_W'(s1_r.hs);
      RPH_BOT: v_nxt = V_W'({s1_r.hs, 1'b0}) + V_W'(rd_data);
      default: v_nxt = '0;
    endcase
    prod = PROD_W'(v_r) * PROD_W'(DIV9_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= s0_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r                 <= s0;
      v_r                  <= v_nxt;
      s2_row_end_r         <= s1_r.row_end;
      s2_frame_end_r       <= s1_r.frame_end;
      out_item_r.pixel_out <= PIX_W'(prod >> DIV9_SHIFT);
      out_item_r.row_end   <= s2_row_end_r;
      out_item_r.frame_end <= s2_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: design/image_scale_two_thirds_area.sv
`default_nettype none
// channel   direction  ports                        payload
// in        input      in_valid / in_stall          pixel_in, frame_start
// out       output     out_valid / out_stall        pixel_out, row_end, frame_end
// cfg       input      cfg_wr_en, cfg_index         cfg_wdata (image_width, image_height)
//
// One pixel per clock, back to back, unless a stalled result is held on out; a result
// is valid on out after the s1, s2 and out registers of the filter.
// The rate is set by the single line store port: at most one read and one write per pixel.
// Stall on out with a valid result freezes the whole pipe and raises in_stall in
// the same cycle.
// Reset clears counters and sets config to its defaults; the line store is not cleared and needs
// no sweep, so items are taken right after reset.

module image_scale_two_thirds_area #(
  parameter int MAX_WIDTH = isa23_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [isa23_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isa23_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  isa23_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output isa23_pkg::out_item_t              out_item
);
  import isa23_pkg::*;

  localparam int STORE_DEPTH = (MAX_WIDTH / 3) * 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic              adv;
  logic              lane_valid;
  lane_t             lane;
  store_ctl_t        st_ctl;
  logic [ADDR_W-1:0] st_addr;
  logic [HS_W-1:0]   st_wdata, rd_data;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  isa23_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .adv        (adv),
    .lane_valid (lane_valid),
    .lane       (lane),
    .st_ctl     (st_ctl),
    .st_addr    (st_addr),
    .st_wdata   (st_wdata)
  );

  isa23_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .addr    (st_addr),
    .wdata   (st_wdata),
    .rd_data (rd_data)
  );

  isa23_filt u_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s0_valid  (lane_valid),
    .s0        (lane),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: design/isa23_chk.sv
`default_nettype none

module isa23_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire isa23_pkg::out_item_t             out_item
);
  import isa23_pkg::*;

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.frame_end || out_item.row_end))
    else $error("frame_end without row_end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not track output backpressure");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("output item right after reset");

endmodule

bind image_scale_two_thirds_area isa23_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
